// File: src/abt_pkg.sv
package abt_pkg;

    // window geometry
    localparam int WINDOW_DEPTH = 16;
    localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

    // operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // register indexes
    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_MARGIN  = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_VOLUME  = 2'd3;

    localparam int ADDR_W = 4;

    // register reset values
    localparam logic        MODE_RST    = 1'b1;
    localparam logic [15:0] MARGIN_RST  = 16'd100;
    localparam logic [15:0] TIMEOUT_RST = 16'd100;
    localparam logic [6:0]  VOLUME_RST  = 7'd0;
    localparam logic [6:0]  VOLUME_MUTE = 7'd4;

    // smoothing weights
    localparam int NUM_W = 23;
    localparam logic [NUM_W-1:0] W_LEVEL_OLD  = 23'd60;
    localparam logic [NUM_W-1:0] W_LEVEL_NEW  = 23'd40;
    localparam logic [NUM_W-1:0] W_THRESH_OLD = 23'd90;
    localparam logic [NUM_W-1:0] W_THRESH_NEW = 23'd10;

    // divide by 100 as multiply by ceil(2^30/100), exact for numerators below 2^23
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
    localparam int PROD_W      = NUM_W + RECIP_W;

    typedef struct packed {
        logic        operation;
        logic [15:0] bass_level;
        logic [15:0] treble_level;
    } req_t;

    typedef struct packed {
        logic trigger_on;
        logic no_signal;
    } rsp_t;

    typedef struct packed {
        logic        trigger_mode;
        logic [15:0] trigger_margin;
        logic [15:0] silence_timeout;
        logic [6:0]  volume_percent;
    } cfg_t;

    typedef struct packed {
        logic latch;
        logic wr_window;
        logic scan_clear;
        logic scan_step;
        logic num_load;
        logic num_thr;
        logic mul_load;
        logic upd_level;
        logic upd_thresh;
        logic tick;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
    } sts_t;

endpackage

// File: src/abt_regs.sv
module abt_regs (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [abt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output abt_pkg::cfg_t          cfg
);
    import abt_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_mode    <= MODE_RST;
            cfg_reg.trigger_margin  <= MARGIN_RST;
            cfg_reg.silence_timeout <= TIMEOUT_RST;
            cfg_reg.volume_percent  <= VOLUME_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MODE:    cfg_reg.trigger_mode    <= pwdata[0];
                REG_MARGIN:  cfg_reg.trigger_margin  <= pwdata[15:0];
                REG_TIMEOUT: cfg_reg.silence_timeout <= pwdata[15:0];
                REG_VOLUME:  cfg_reg.volume_percent  <= pwdata[6:0];
                default:     cfg_reg.trigger_mode    <= cfg_reg.trigger_mode;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MODE:    prdata = {31'd0, cfg_reg.trigger_mode};
            REG_MARGIN:  prdata = {16'd0, cfg_reg.trigger_margin};
            REG_TIMEOUT: prdata = {16'd0, cfg_reg.silence_timeout};
            REG_VOLUME:  prdata = {25'd0, cfg_reg.volume_percent};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

// File: src/abt_ctrl.sv
module abt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_op,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    input  abt_pkg::sts_t sts,
    output abt_pkg::cmd_t cmd
);
    import abt_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WRITE = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_NUM_L = 4'd3;
    localparam logic [3:0] S_MUL_L = 4'd4;
    localparam logic [3:0] S_UPD_L = 4'd5;
    localparam logic [3:0] S_NUM_T = 4'd6;
    localparam logic [3:0] S_MUL_T = 4'd7;
    localparam logic [3:0] S_UPD_T = 4'd8;
    localparam logic [3:0] S_TICK  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       out_free;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = (req_op == OP_TICK) ? S_TICK : S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.wr_window  = 1'b1;
                cmd.scan_clear = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = S_NUM_L;
            end
            S_NUM_L:
            begin
                cmd.num_load = 1'b1;
                state_next   = S_MUL_L;
            end
            S_MUL_L:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_UPD_L;
            end
            S_UPD_L:
            begin
                cmd.upd_level = 1'b1;
                state_next    = S_NUM_T;
            end
            S_NUM_T:
            begin
                cmd.num_load = 1'b1;
                cmd.num_thr  = 1'b1;
                state_next   = S_MUL_T;
            end
            S_MUL_T:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_UPD_T;
            end
            S_UPD_T:
            begin
                cmd.upd_thresh = 1'b1;
                state_next     = S_DONE;
            end
            S_TICK:
            begin
                cmd.tick   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;
        if (cmd.out_load)
            rsp_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// File: src/abt_dpath.sv
module abt_dpath (
    input  logic          clk,
    input  logic          rst_n,
    input  abt_pkg::req_t req,
    input  abt_pkg::cfg_t cfg,
    input  abt_pkg::cmd_t cmd,
    output abt_pkg::sts_t sts,
    output abt_pkg::rsp_t rsp
);
    import abt_pkg::*;

    // window memory, entries that were never written read as zero
    logic [15:0]             win_mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] win_vld_reg;
    logic [IDX_W-1:0]        wr_idx_reg;
    logic [IDX_W-1:0]        rd_idx;
    logic [15:0]             rd_data_reg;
    logic                    rd_vld_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [15:0]             entry;

    logic [15:0]       x_reg;
    logic [15:0]       lo_reg, hi_reg;
    logic [15:0]       mid;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [PROD_W-1:0] prod_reg;
    logic [15:0]       quot;

    logic [15:0] level_reg, thresh_reg;
    logic        trig_reg, trig_next;
    logic        silent_reg, silent_next;
    logic [15:0] sil_cnt_reg, sil_cnt_next;
    logic [16:0] thr_plus;
    rsp_t        rsp_reg;

    assign sts.scan_last = (cnt_reg == CNT_W'(WINDOW_DEPTH));
    assign rd_idx = (cnt_reg < CNT_W'(WINDOW_DEPTH)) ? cnt_reg[IDX_W-1:0] : '0;
    assign entry  = rd_vld_reg ? rd_data_reg : 16'd0;
    assign mid    = 16'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign quot   = prod_reg[RECIP_SHIFT +: 16];
    assign rsp    = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_window)
            win_mem[wr_idx_reg] <= x_reg;
        rd_data_reg <= win_mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_vld_reg <= '0;
            wr_idx_reg  <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= win_vld_reg[rd_idx];
            if (cmd.wr_window)
            begin
                win_vld_reg[wr_idx_reg] <= 1'b1;
                if (wr_idx_reg == IDX_W'(WINDOW_DEPTH - 1))
                    wr_idx_reg <= '0;
                else
                    wr_idx_reg <= wr_idx_reg + 1'b1;
            end
        end
    end

    // min/max scan, read data arrives in the cycle after its read address
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            x_reg <= (cfg.trigger_mode && (req.treble_level > req.bass_level)) ?
                     req.treble_level : req.bass_level;
        if (cmd.scan_clear)
            cnt_reg <= '0;
        else if (cmd.scan_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                lo_reg <= entry;
                hi_reg <= entry;
            end
            else if (cnt_reg != '0)
            begin
                if (entry < lo_reg)
                    lo_reg <= entry;
                if (entry > hi_reg)
                    hi_reg <= entry;
            end
        end
    end

    always_comb
    begin
        if (cmd.num_thr)
            num_next = {7'd0, thresh_reg} * W_THRESH_OLD + {7'd0, mid} * W_THRESH_NEW;
        else
            num_next = {7'd0, level_reg} * W_LEVEL_OLD + {7'd0, x_reg} * W_LEVEL_NEW;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.num_load)
            num_reg <= num_next;
        if (cmd.mul_load)
            prod_reg <= {{RECIP_W{1'b0}}, num_reg} * {{NUM_W{1'b0}}, RECIP_100};
        if (cmd.out_load)
        begin
            rsp_reg.trigger_on <= trig_reg;
            rsp_reg.no_signal  <= silent_reg;
        end
    end

    // tick: hysteresis, silence counter, mute
    assign thr_plus = {1'b0, thresh_reg} + {1'b0, cfg.trigger_margin};

    always_comb
    begin
        trig_next    = trig_reg;
        silent_next  = silent_reg;
        sil_cnt_next = sil_cnt_reg;
        if (level_reg <= thresh_reg)
        begin
            trig_next = 1'b0;
            if (sil_cnt_reg >= cfg.silence_timeout)
            begin
                silent_next  = 1'b1;
                sil_cnt_next = 16'd0;
            end
            else
                sil_cnt_next = sil_cnt_reg + 16'd1;
        end
        else if ({1'b0, level_reg} > thr_plus)
        begin
            trig_next    = 1'b1;
            silent_next  = 1'b0;
            sil_cnt_next = 16'd0;
        end
        if (cfg.volume_percent < VOLUME_MUTE)
        begin
            trig_next   = 1'b0;
            silent_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= 16'd0;
            thresh_reg  <= 16'd0;
            trig_reg    <= 1'b0;
            silent_reg  <= 1'b1;
            sil_cnt_reg <= 16'd0;
        end
        else
        begin
            if (cmd.upd_level)
                level_reg <= quot;
            if (cmd.upd_thresh)
                thresh_reg <= quot;
            if (cmd.tick)
            begin
                trig_reg    <= trig_next;
                silent_reg  <= silent_next;
                sil_cnt_reg <= sil_cnt_next;
            end
        end
    end

endmodule

// File: src/audio_beat_trigger.sv
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req (operation, bass_level, treble_level)
// rsp       out        rsp_valid / rsp_ready  rsp (trigger_on, no_signal)
// apb       in         psel, penable, pwrite  paddr, pwdata, prdata, pready
//
// one request at a time; a display tick runs through the tick and done states
// a band sample walks write, scan and smoothing before its result, the longest part being the
// min/max scan reading one window entry per cycle from the window memory
// a finished result sits in the output register, so the next request is taken
// while it waits; a stalled rsp holds the block only at its next result
// rst_n is asynchronous; the window reads as all zero after reset through
// per-entry valid bits, so no clearing pass is needed
module audio_beat_trigger (
    input  logic                       clk,
    input  logic                       rst_n,

    // request channel
    input  logic                       req_valid,
    output logic                       req_ready,
    input  abt_pkg::req_t              req,

    // result channel
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output abt_pkg::rsp_t              rsp,

    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [abt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import abt_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    // configuration registers: mode, margin, silence timeout, volume
    abt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: sample path walks write, scan, two smoothing passes; tick is one step
    abt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_op    (req.operation),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // window memory, min/max scan, shared divide-by-100 multiplier, trigger flags
    abt_dpath u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule
